### design/iumix_pkg.sv
// Package for the interpolating upsampler and mixer.
// Holds widths, the controller state type and the command and status structs.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package iumix_pkg;

	localparam int unsigned SAMPLE_W     = 16;
	localparam int unsigned FACTOR_W     = 3;
	localparam int unsigned MUSIC_FRAMES = 4;
	localparam int unsigned FRAME_IDX_W  = 2;

	localparam logic [FACTOR_W-1:0] FACTOR_RESET = 3'd2;
	localparam logic [FACTOR_W-1:0] FACTOR_ONE   = 3'd1;

	// Reciprocal of three, ceil(2^20 / 3); exact for dividends below 2^19.
	localparam int unsigned         RECIP3_SHIFT = 20;
	localparam logic [18:0]         RECIP3       = 19'd349526;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_PUSH
	} iumix_state_t;

	typedef struct packed {
		logic take_in;
		logic mul;
		logic div;
		logic push;
	} iumix_cmd_t;

	typedef struct packed {
		logic can_push;
		logic last;
	} iumix_stat_t;

endpackage

`default_nettype wire

### design/iumix_ctrl.sv
// Controller of the interpolating upsampler and mixer.
// Walks each output frame through multiply, divide and push; uses iumix_pkg.
`default_nettype none

module iumix_ctrl
	import iumix_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  iumix_stat_t stat,
	output iumix_cmd_t  cmd
);

	iumix_state_t state_q;
	iumix_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_MUL;
			end
			ST_MUL:  state_d = ST_DIV;
			ST_DIV:  state_d = ST_PUSH;
			ST_PUSH: begin
				if (stat.can_push) state_d = stat.last ? ST_IDLE : ST_MUL;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		cmd         = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.take_in = in_valid;
			end
			ST_MUL:  cmd.mul  = 1'b1;
			ST_DIV:  cmd.div  = 1'b1;
			ST_PUSH: cmd.push = stat.can_push;
			default: cmd      = '0;
		endcase
	end

endmodule

`default_nettype wire

### design/iumix_datapath.sv
// Datapath of the interpolating upsampler and mixer.
// Holds the factor register, effects history, scaling, division and output register.
// Uses iumix_pkg; driven by commands from iumix_ctrl.
`default_nettype none

module iumix_datapath
	import iumix_pkg::*;
#(
	parameter int unsigned FACTOR_CAP = 4
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_valid,
	input  wire  [FACTOR_W-1:0]        cfg_data,
	input  wire  signed [SAMPLE_W-1:0] sfx_left,
	input  wire  signed [SAMPLE_W-1:0] sfx_right,
	input  wire  signed [SAMPLE_W-1:0] music_left  [MUSIC_FRAMES],
	input  wire  signed [SAMPLE_W-1:0] music_right [MUSIC_FRAMES],
	input  iumix_cmd_t                 cmd,
	output iumix_stat_t                stat,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic signed [SAMPLE_W-1:0] mixed_left,
	output logic signed [SAMPLE_W-1:0] mixed_right,
	output logic                       last_of_run
);

	localparam int unsigned CAP_RAW = (FACTOR_CAP > MUSIC_FRAMES) ? MUSIC_FRAMES : FACTOR_CAP;
	localparam int unsigned CAP     = (CAP_RAW < 1) ? 1 : CAP_RAW;
	localparam logic [FACTOR_W-1:0] CAP_F = FACTOR_W'(CAP);

	logic        [FACTOR_W-1:0]    factor_q;
	logic        [FACTOR_W-1:0]    eff_f_q;
	logic        [FACTOR_W-1:0]    eff_f_d;
	logic        [FRAME_IDX_W-1:0] j_q;
	logic signed [SAMPLE_W-1:0]    cur_l_q, cur_r_q;
	logic signed [SAMPLE_W-1:0]    a_l_q, a_r_q;
	logic signed [SAMPLE_W:0]      diff_l_q, diff_r_q;
	logic signed [SAMPLE_W-1:0]    mus_l_q [MUSIC_FRAMES];
	logic signed [SAMPLE_W-1:0]    mus_r_q [MUSIC_FRAMES];
	logic        [17:0]            mag_l_s1, mag_r_s1;
	logic                          neg_l_s1, neg_r_s1;
	logic signed [SAMPLE_W:0]      q_l_s2, q_r_s2;
	logic                          out_valid_q;
	logic signed [SAMPLE_W-1:0]    out_l_q, out_r_q;
	logic                          out_last_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			factor_q <= FACTOR_RESET;
		end else if (cfg_valid) begin
			factor_q <= cfg_data;
		end
	end

	always_comb begin
		if (factor_q == '0) begin
			eff_f_d = FACTOR_ONE;
		end else if (factor_q > CAP_F) begin
			eff_f_d = CAP_F;
		end else begin
			eff_f_d = factor_q;
		end
	end

	// Effects history; the current frame resets to zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_l_q <= '0;
			cur_r_q <= '0;
			j_q     <= '0;
		end else if (cmd.take_in) begin
			cur_l_q <= sfx_left;
			cur_r_q <= sfx_right;
			j_q     <= '0;
		end else if (cmd.push) begin
			j_q     <= j_q + FRAME_IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			eff_f_q  <= eff_f_d;
			a_l_q    <= cur_l_q;
			a_r_q    <= cur_r_q;
			diff_l_q <= (SAMPLE_W+1)'(sfx_left) - (SAMPLE_W+1)'(cur_l_q);
			diff_r_q <= (SAMPLE_W+1)'(sfx_right) - (SAMPLE_W+1)'(cur_r_q);
			for (int k = 0; k < MUSIC_FRAMES; k++) begin
				mus_l_q[k] <= music_left[k];
				mus_r_q[k] <= music_right[k];
			end
		end
	end

	// Stage one: magnitude of the difference scaled by the frame index.
	logic signed [SAMPLE_W:0] abs_l, abs_r;

	always_comb begin
		abs_l = diff_l_q[SAMPLE_W] ? -diff_l_q : diff_l_q;
		abs_r = diff_r_q[SAMPLE_W] ? -diff_r_q : diff_r_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			mag_l_s1 <= 18'(abs_l[SAMPLE_W-1:0]) * 18'(j_q);
			mag_r_s1 <= 18'(abs_r[SAMPLE_W-1:0]) * 18'(j_q);
			neg_l_s1 <= diff_l_q[SAMPLE_W];
			neg_r_s1 <= diff_r_q[SAMPLE_W];
		end
	end

	// Stage two: divide the magnitude by the factor, then restore the sign.
	function automatic logic [SAMPLE_W-1:0] div_by_factor(input logic [17:0] m,
		input logic [FACTOR_W-1:0] f);
		logic [36:0] p3;
		logic [17:0] q;
		p3 = 37'(m) * 37'(RECIP3);
		unique case (f)
			3'd2:    q = m >> 1;
			3'd3:    q = 18'(p3[36:RECIP3_SHIFT]);
			3'd4:    q = m >> 2;
			default: q = m;
		endcase
		return q[SAMPLE_W-1:0];
	endfunction

	logic signed [SAMPLE_W:0] ql, qr;

	always_comb begin
		ql = (SAMPLE_W+1)'(div_by_factor(mag_l_s1, eff_f_q));
		qr = (SAMPLE_W+1)'(div_by_factor(mag_r_s1, eff_f_q));
	end

	always_ff @(posedge clk) begin
		if (cmd.div) begin
			q_l_s2 <= neg_l_s1 ? -ql : ql;
			q_r_s2 <= neg_r_s1 ? -qr : qr;
		end
	end

	// Push: add start value and music, saturate, load the output register.
	function automatic logic signed [SAMPLE_W-1:0] mix_sat(input logic signed [SAMPLE_W-1:0] a,
		input logic signed [SAMPLE_W:0] q, input logic signed [SAMPLE_W-1:0] m);
		logic signed [SAMPLE_W+2:0] s;
		s = (SAMPLE_W+3)'(a) + (SAMPLE_W+3)'(q) + (SAMPLE_W+3)'(m);
		if (s > (SAMPLE_W+3)'(32767)) begin
			return 16'sh7FFF;
		end else if (s < -(SAMPLE_W+3)'(32768)) begin
			return 16'sh8000;
		end
		return s[SAMPLE_W-1:0];
	endfunction

	logic last_now;

	assign last_now = ({1'b0, j_q} == (eff_f_q - FACTOR_ONE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_l_q    <= mix_sat(a_l_q, q_l_s2, mus_l_q[j_q]);
			out_r_q    <= mix_sat(a_r_q, q_r_s2, mus_r_q[j_q]);
			out_last_q <= last_now;
		end
	end

	assign stat.can_push = !out_valid_q || out_ready;
	assign stat.last     = last_now;
	assign out_valid     = out_valid_q;
	assign mixed_left    = out_l_q;
	assign mixed_right   = out_r_q;
	assign last_of_run   = out_last_q;

endmodule

`default_nettype wire

### design/interp_upsample_mixer_unit.sv
// Top level of the interpolating upsampler and mixer.
// Instantiates iumix_ctrl and iumix_datapath; uses iumix_pkg.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_ready    sfx_left/right, music_left/right_0..3
//   output    out        out_valid / out_ready  mixed_left, mixed_right, last_of_run
//   config    in         cfg_valid / cfg_ready  cfg_data (upsample_factor)
//
// An input request is taken only while the controller is idle. Each output frame then
// passes through three steps (index scaling, division by the factor, mix and saturate).
// The division by three is a registered multiplication by a reciprocal.
// The asynchronous reset clears the controller, the output valid flag, the stored effects
// frame (to zero) and sets the factor to two. A stalled output holds the push step until
// the waiting result is taken; the output register lets the next frame be computed
// meanwhile. Configuration requests are always taken.
`default_nettype none

module interp_upsample_mixer_unit
	import iumix_pkg::*;
#(
	parameter int unsigned MAX_FACTOR = 4
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        cfg_valid,
	output logic                       cfg_ready,
	input  wire  [FACTOR_W-1:0]        cfg_data,
	input  wire                        in_valid,
	output logic                       in_ready,
	input  wire  signed [SAMPLE_W-1:0] sfx_left,
	input  wire  signed [SAMPLE_W-1:0] sfx_right,
	input  wire  signed [SAMPLE_W-1:0] music_left_0,
	input  wire  signed [SAMPLE_W-1:0] music_right_0,
	input  wire  signed [SAMPLE_W-1:0] music_left_1,
	input  wire  signed [SAMPLE_W-1:0] music_right_1,
	input  wire  signed [SAMPLE_W-1:0] music_left_2,
	input  wire  signed [SAMPLE_W-1:0] music_right_2,
	input  wire  signed [SAMPLE_W-1:0] music_left_3,
	input  wire  signed [SAMPLE_W-1:0] music_right_3,
	output logic                       out_valid,
	input  wire                        out_ready,
	output logic signed [SAMPLE_W-1:0] mixed_left,
	output logic signed [SAMPLE_W-1:0] mixed_right,
	output logic                       last_of_run
);

	iumix_cmd_t  cmd;
	iumix_stat_t stat;

	// The music frames are gathered into arrays indexed by output frame.
	logic signed [SAMPLE_W-1:0] music_l [MUSIC_FRAMES];
	logic signed [SAMPLE_W-1:0] music_r [MUSIC_FRAMES];

	assign music_l[0] = music_left_0;
	assign music_l[1] = music_left_1;
	assign music_l[2] = music_left_2;
	assign music_l[3] = music_left_3;
	assign music_r[0] = music_right_0;
	assign music_r[1] = music_right_1;
	assign music_r[2] = music_right_2;
	assign music_r[3] = music_right_3;

	// The factor register never refuses a write.
	assign cfg_ready = 1'b1;

	iumix_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	iumix_datapath #(
		.FACTOR_CAP (MAX_FACTOR)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.sfx_left    (sfx_left),
		.sfx_right   (sfx_right),
		.music_left  (music_l),
		.music_right (music_r),
		.cmd         (cmd),
		.stat        (stat),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.mixed_left  (mixed_left),
		.mixed_right (mixed_right),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire

### design/iumix_checker.sv
// Port-level checker for the interpolating upsampler and mixer.
// Bound to interp_upsample_mixer_unit; uses iumix_pkg for widths.
`default_nettype none

module iumix_checker
	import iumix_pkg::*;
(
	input wire                        clk,
	input wire                        arst_n,
	input wire                        in_valid,
	input wire                        in_ready,
	input wire                        out_valid,
	input wire                        out_ready,
	input wire signed [SAMPLE_W-1:0]  mixed_left,
	input wire signed [SAMPLE_W-1:0]  mixed_right,
	input wire                        last_of_run
);

	// A waiting result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result withdrawn before it was taken");

	// A waiting result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(mixed_left) && $stable(mixed_right)
			&& $stable(last_of_run))
		else $error("result payload changed while stalled");

	// One request at a time: the block is busy in the cycle after taking one.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second request taken without a gap");

	// While frames of a request remain, no new request is taken.
	a_busy_mid_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last_of_run |-> !in_ready)
		else $error("block idle before the last frame of a run");

endmodule

bind interp_upsample_mixer_unit iumix_checker u_iumix_checker (.*);

`default_nettype wire

### tb/iumix_mix_monitor.sv
`timescale 1ns / 100ps
// Watching checker for the interpolating upsampler and mixer: predicts every
// mixed output frame from the accepted requests and compares it with the block.
// Depends on iumix_pkg for widths and the reset factor.

module iumix_mix_monitor
	import iumix_pkg::*;
#(
	parameter int unsigned MAX_FACTOR = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	input  logic                                  cfg_ready,
	input  logic [FACTOR_W-1:0]                   cfg_data,
	input  logic                                  in_valid,
	input  logic                                  in_ready,
	input  logic [SAMPLE_W-1:0]                   sfx_left,
	input  logic [SAMPLE_W-1:0]                   sfx_right,
	input  logic [MUSIC_FRAMES-1:0][SAMPLE_W-1:0] music_left,
	input  logic [MUSIC_FRAMES-1:0][SAMPLE_W-1:0] music_right,
	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic [SAMPLE_W-1:0]                   mixed_left,
	input  logic [SAMPLE_W-1:0]                   mixed_right,
	input  logic                                  last_of_run,
	output int                                    frames_outstanding,
	output int                                    mismatch_count
);

	localparam int FRAME_CAP = (MAX_FACTOR < MUSIC_FRAMES) ? MAX_FACTOR : MUSIC_FRAMES;
	localparam int SAT_HI    = 32767;
	localparam int SAT_LO    = -32768;

	typedef struct packed {
		logic [SAMPLE_W-1:0] left;
		logic [SAMPLE_W-1:0] right;
		logic                last;
	} mixed_frame_t;

	mixed_frame_t        expected_frames[$];
	logic [FACTOR_W-1:0] factor_reg;
	int                  prev_left;
	int                  prev_right;

	// Interpolated effects value plus music, saturated; SV integer division
	// truncates toward zero, as the block must.
	function automatic logic [SAMPLE_W-1:0] mix_channel(int a, int b, int j, int f, int music);
		int sum;
		sum = a + ((b - a) * j) / f + music;
		if (sum > SAT_HI)
			sum = SAT_HI;
		else if (sum < SAT_LO)
			sum = SAT_LO;
		return sum[SAMPLE_W-1:0];
	endfunction

	function automatic int frames_per_item(logic [FACTOR_W-1:0] fr);
		if (fr == 0)
			return 1;
		if (int'(fr) > FRAME_CAP)
			return FRAME_CAP;
		return int'(fr);
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		mixed_frame_t want;
		mixed_frame_t got;
		int           f;
		if (!arst_n) begin
			factor_reg = FACTOR_RESET;
			prev_left = 0;
			prev_right = 0;
			expected_frames.delete();
			mismatch_count = 0;
			frames_outstanding <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{mixed_left, mixed_right, last_of_run};
				if (expected_frames.size() == 0) begin
					mismatch_count++;
					$display("%0t: unexpected frame: left %0d right %0d last %0b", $time,
						$signed(got.left), $signed(got.right), got.last);
				end else begin
					want = expected_frames.pop_front();
					if (got.left !== want.left || got.right !== want.right
							|| got.last !== want.last) begin
						mismatch_count++;
						$display("%0t: frame mismatch: expected left %0d right %0d last %0b,%s",
							$time, $signed(want.left), $signed(want.right), want.last,
							$sformatf(" actual left %0d right %0d last %0b",
								$signed(got.left), $signed(got.right), got.last));
					end
				end
			end
			if (in_valid && in_ready) begin
				f = frames_per_item(factor_reg);
				for (int j = 0; j < f; j++) begin
					want.left = mix_channel(prev_left, int'($signed(sfx_left)), j, f,
						int'($signed(music_left[j])));
					want.right = mix_channel(prev_right, int'($signed(sfx_right)), j, f,
						int'($signed(music_right[j])));
					want.last = (j == f - 1);
					expected_frames.push_back(want);
				end
				prev_left = int'($signed(sfx_left));
				prev_right = int'($signed(sfx_right));
			end
			if (cfg_valid && cfg_ready)
				factor_reg = cfg_data;
			frames_outstanding <= expected_frames.size();
		end
	end

endmodule

### tb/interp_upsample_mixer_unit_test.sv
`timescale 1ns / 100ps
// Test top for interp_upsample_mixer_unit: generates clock, reset, configuration
// and stimulus requests and gives the verdict. Uses iumix_pkg and iumix_mix_monitor.

module interp_upsample_mixer_unit_test;
	import iumix_pkg::*;

	// Generous bound on the length of a correct run.
	localparam int LIMIT = 200000;
	localparam int N_PHASES = 8;
	localparam int PHASE_ITEMS = 25;
	localparam int QUIET_ITEMS = 30;

	localparam logic [SAMPLE_W-1:0] S_MAX = 16'h7fff;
	localparam logic [SAMPLE_W-1:0] S_MIN = 16'h8000;
	localparam logic [SAMPLE_W-1:0] S_ZERO = 16'h0000;

	// One input request: an effects frame and the four music frames it mixes into.
	typedef struct packed {
		logic [SAMPLE_W-1:0]                   sfx_l;
		logic [SAMPLE_W-1:0]                   sfx_r;
		logic [MUSIC_FRAMES-1:0][SAMPLE_W-1:0] mus_l;
		logic [MUSIC_FRAMES-1:0][SAMPLE_W-1:0] mus_r;
	} effects_item_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [FACTOR_W-1:0] cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	effects_item_t       item = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [SAMPLE_W-1:0] mixed_left;
	logic [SAMPLE_W-1:0] mixed_right;
	logic                last_of_run;

	// Set for the closing stretch of the run, where neither side idles.
	logic                quiet = 1'b0;
	int                  frames_outstanding;
	int                  mismatch_count;
	int                  cycle_count;

	interp_upsample_mixer_unit #(
		.MAX_FACTOR(4)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sfx_left     (item.sfx_l),
		.sfx_right    (item.sfx_r),
		.music_left_0 (item.mus_l[0]),
		.music_right_0(item.mus_r[0]),
		.music_left_1 (item.mus_l[1]),
		.music_right_1(item.mus_r[1]),
		.music_left_2 (item.mus_l[2]),
		.music_right_2(item.mus_r[2]),
		.music_left_3 (item.mus_l[3]),
		.music_right_3(item.mus_r[3]),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.mixed_left   (mixed_left),
		.mixed_right  (mixed_right),
		.last_of_run  (last_of_run)
	);

	iumix_mix_monitor #(
		.MAX_FACTOR(4)
	) i_monitor (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_data          (cfg_data),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.sfx_left          (item.sfx_l),
		.sfx_right         (item.sfx_r),
		.music_left        (item.mus_l),
		.music_right       (item.mus_r),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.mixed_left        (mixed_left),
		.mixed_right       (mixed_right),
		.last_of_run       (last_of_run),
		.frames_outstanding(frames_outstanding),
		.mismatch_count    (mismatch_count)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: if the block hangs, the run still ends with a verdict.
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	// Receiver: ready drops for stretches of random length, separated by stretches of
	// varying length with no stall at all. Only one assignment lands in any time step.
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			out_ready <= 1'b1;
			repeat ($urandom_range(0, 12)) @(posedge clk);
		end
	end

	// Mostly full-range values, with the extremes and small values near zero
	// turning up often enough to hit saturation and the rounding of small steps.
	function automatic logic [SAMPLE_W-1:0] random_sample();
		case ($urandom_range(0, 7))
			0: random_sample = S_MAX;
			1: random_sample = S_MIN;
			2: random_sample = SAMPLE_W'($urandom_range(0, 32)) - SAMPLE_W'(16);
			default: random_sample = SAMPLE_W'($urandom);
		endcase
	endfunction

	function automatic effects_item_t random_item();
		effects_item_t it;
		it.sfx_l = random_sample();
		it.sfx_r = random_sample();
		for (int k = 0; k < MUSIC_FRAMES; k++) begin
			it.mus_l[k] = random_sample();
			it.mus_r[k] = random_sample();
		end
		return it;
	endfunction

	// Every music frame carries the same pair, so all output frames of a request share their music.
	function automatic effects_item_t flat_item(logic [SAMPLE_W-1:0] sl, logic [SAMPLE_W-1:0] sr,
			logic [SAMPLE_W-1:0] ml, logic [SAMPLE_W-1:0] mr);
		effects_item_t it;
		it.sfx_l = sl;
		it.sfx_r = sr;
		for (int k = 0; k < MUSIC_FRAMES; k++) begin
			it.mus_l[k] = ml;
			it.mus_r[k] = mr;
		end
		return it;
	endfunction

	// Valid is raised without looking at ready and left high on return, so that a
	// following request can keep it up without a lower-and-raise in one step.
	task automatic send_item(input effects_item_t it);
		in_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic idle_input(input int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// The monitor's count is registered, so the task waits for a clock edge before it first looks.
	task automatic wait_drained();
		do @(posedge clk); while (frames_outstanding != 0);
	endtask

	// The factor is only changed once every frame of the earlier requests is out.
	task automatic write_factor(input logic [FACTOR_W-1:0] value);
		in_valid <= 1'b0;
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Order of the factors in the random part: every register value appears,
	// both ends among them, and the quiet closing phase runs at full factor.
	logic [FACTOR_W-1:0] phase_factor [N_PHASES] = '{3'd1, 3'd3, 3'd0, 3'd7, 3'd2, 3'd5, 3'd6, 3'd4};

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. The reset factor of two comes first: full-scale steps in
		// both directions, with music at the rails to force saturation either way.
		send_item(flat_item(S_MAX, S_MIN, S_MAX, S_MIN));
		send_item(flat_item(S_MIN, S_MAX, S_MAX, S_MIN));

		// Factor three: odd negative and positive steps check that the division
		// truncates toward zero rather than rounding down.
		write_factor(3'd3);
		send_item(flat_item(16'hfffb, 16'h0007, S_ZERO, S_ZERO));
		send_item(flat_item(16'hfff6, 16'h0008, S_ZERO, S_ZERO));
		send_item(flat_item(S_MIN, S_MAX, S_MIN, S_MAX));

		write_factor(3'd4);
		send_item(flat_item(S_MAX, S_MIN, S_MIN, S_MAX));
		send_item(random_item());

		// Factor one: no interpolation, and the unused music frames carry noise
		// that must not reach the output.
		write_factor(3'd1);
		send_item(random_item());
		send_item(flat_item(S_MIN, S_MAX, S_MIN, S_MAX));

		// A factor of zero behaves as one.
		write_factor(3'd0);
		send_item(random_item());
		send_item(flat_item(S_MAX, S_MIN, S_MAX, S_MIN));

		// Factors above four are held at four, the number of music frames carried.
		write_factor(3'd7);
		send_item(flat_item(S_MIN, S_MIN, S_MAX, S_MAX));
		send_item(random_item());
		write_factor(3'd5);
		send_item(random_item());
		write_factor(3'd6);
		send_item(random_item());

		// Random part: one factor per phase, gaps in the input stream at random.
		// Part-way through each phase but the quiet last one, the sender holds off until
		// the block has emptied, so that a request also meets a fully idle block.
		for (int p = 0; p < N_PHASES; p++) begin
			write_factor(phase_factor[p]);
			if (p == N_PHASES - 1)
				quiet = 1'b1;
			for (int n = 0; n < ((p == N_PHASES - 1) ? QUIET_ITEMS : PHASE_ITEMS); n++) begin
				if (n == PHASE_ITEMS / 2 && !quiet) begin
					in_valid <= 1'b0;
					wait_drained();
				end else if (!quiet && $urandom_range(0, 3) == 0) begin
					idle_input($urandom_range(1, 6));
				end
				send_item(random_item());
			end
		end

		// Let the last frames out, then allow a margin for anything unasked for.
		in_valid <= 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);

		if (mismatch_count == 0 && frames_outstanding == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
